// ===== rtl/gip_pkg.sv =====
// Shared types, constants and register map for the ground-to-image projection block.
package gip_pkg;

    localparam int IN_W   = 24;
    localparam int TRIG_W = 16;
    localparam int FOC_W  = 20;
    localparam int CEN_W  = 17;
    localparam int OUT_W  = 18;
    localparam int STAT_W = 2;

    localparam int NUM_W = 80;
    localparam int DEN_W = 64;
    localparam int REM_W = 83;
    localparam int QUO_W = 19;

    localparam logic [FOC_W-1:0]  FOCAL_X_RST   = 20'd433948;
    localparam logic [FOC_W-1:0]  FOCAL_Y_RST   = 20'd435026;
    localparam logic [CEN_W-1:0]  CENTER_X_RST  = 17'd26424;
    localparam logic [CEN_W-1:0]  CENTER_Y_RST  = 17'd39950;
    localparam logic [TRIG_W-1:0] COS_PITCH_RST = 16'd16384;
    localparam logic [TRIG_W-1:0] SIN_PITCH_RST = 16'd0;
    localparam logic [TRIG_W-1:0] COS_YAW_RST   = 16'd16384;
    localparam logic [TRIG_W-1:0] SIN_YAW_RST   = 16'd0;

    localparam logic signed [20:0] OUT_MAX = 21'sd131071;
    localparam logic signed [20:0] OUT_MIN = -21'sd131072;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_COS_PITCH = 3'd4,
        REG_SIN_PITCH = 3'd5,
        REG_COS_YAW   = 3'd6,
        REG_SIN_YAW   = 3'd7
    } gip_reg_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_VALID   = 2'd0,
        STAT_HORIZON = 2'd1,
        STAT_SAT     = 2'd2
    } gip_stat_t;

    typedef struct packed {
        logic valid;
        logic horizon;
        logic neg_u;
        logic neg_v;
    } gip_tag_t;

endpackage

// ===== rtl/ground_to_image_projection_top.sv =====
// Top level of the ground-to-image projection pipeline with its register port.
// Each accepted request passes the operand stages, divider and output register.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// The divider resolves one quotient bit per stage.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
module ground_to_image_projection_top
    import gip_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // ground_x [23:0], ground_y [47:24]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // image_u [17:0], image_v [35:18], zero [39:36]
    output logic [1:0]  m_tuser,   // status [1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [FOC_W-1:0]         focal_x_reg, focal_y_reg;
    logic [CEN_W-1:0]         center_x_reg, center_y_reg;
    logic signed [TRIG_W-1:0] cos_pitch_reg, sin_pitch_reg, cos_yaw_reg, sin_yaw_reg;
    gip_reg_t                 reg_sel;
    logic                     en;

    assign pready  = 1'b1;
    assign reg_sel = gip_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg   <= FOCAL_X_RST;
            focal_y_reg   <= FOCAL_Y_RST;
            center_x_reg  <= CENTER_X_RST;
            center_y_reg  <= CENTER_Y_RST;
            cos_pitch_reg <= COS_PITCH_RST;
            sin_pitch_reg <= SIN_PITCH_RST;
            cos_yaw_reg   <= COS_YAW_RST;
            sin_yaw_reg   <= SIN_YAW_RST;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_sel)
                REG_FOCAL_X:   focal_x_reg   <= pwdata[FOC_W-1:0];
                REG_FOCAL_Y:   focal_y_reg   <= pwdata[FOC_W-1:0];
                REG_CENTER_X:  center_x_reg  <= pwdata[CEN_W-1:0];
                REG_CENTER_Y:  center_y_reg  <= pwdata[CEN_W-1:0];
                REG_COS_PITCH: cos_pitch_reg <= pwdata[TRIG_W-1:0];
                REG_SIN_PITCH: sin_pitch_reg <= pwdata[TRIG_W-1:0];
                REG_COS_YAW:   cos_yaw_reg   <= pwdata[TRIG_W-1:0];
                REG_SIN_YAW:   sin_yaw_reg   <= pwdata[TRIG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FOCAL_X:   prdata = 32'(focal_x_reg);
            REG_FOCAL_Y:   prdata = 32'(focal_y_reg);
            REG_CENTER_X:  prdata = 32'(center_x_reg);
            REG_CENTER_Y:  prdata = 32'(center_y_reg);
            REG_COS_PITCH: prdata = 32'(cos_pitch_reg);
            REG_SIN_PITCH: prdata = 32'(sin_pitch_reg);
            REG_COS_YAW:   prdata = 32'(cos_yaw_reg);
            REG_SIN_YAW:   prdata = 32'(sin_yaw_reg);
            default:       prdata = '0;
        endcase
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [6:1] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:1], s_tvalid};
        end
    end

    logic signed [IN_W-1:0] gx, gy;
    assign gx = s_tdata[23:0];
    assign gy = s_tdata[47:24];

    // Stage 1: yaw products.
    logic signed [39:0] sx_reg, cyy_reg, cx_reg, syy_reg;
    // Stage 2: rotated coordinates.
    logic signed [40:0] s_reg, c_reg;
    // Stage 3: pitch and focal products.
    logic signed [56:0] cps_reg, sps_reg;
    logic signed [61:0] fxc_reg;
    // Stage 4: denominator, v numerator term and u numerator.
    logic signed [57:0] d_reg, t_reg;
    logic signed [61:0] nu_reg;
    // Stage 5: magnitudes and split v product.
    logic               hor5_reg, negu5_reg, negv5_reg;
    logic [60:0]        mu_reg;
    logic [56:0]        d5_reg;
    logic [48:0]        pvl_reg;
    logic [47:0]        pvh_reg;
    // Stage 6: divider operands.
    logic               hor6_reg, negu6_reg, negv6_reg;
    logic [NUM_W-1:0]   numu_reg, numv_reg;
    logic [DEN_W-1:0]   denu_reg, denv_reg;

    logic [56:0]        mt_next;
    logic [77:0]        nv_next;

    assign mt_next = t_reg[57] ? 57'(-t_reg) : t_reg[56:0];
    assign nv_next = {pvh_reg, 29'd0} + 78'(pvl_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg    <= sin_yaw_reg * gx;
            cyy_reg   <= cos_yaw_reg * gy;
            cx_reg    <= cos_yaw_reg * gx;
            syy_reg   <= sin_yaw_reg * gy;

            s_reg     <= 41'(sx_reg) + 41'(cyy_reg);
            c_reg     <= 41'(cx_reg) - 41'(syy_reg);

            cps_reg   <= cos_pitch_reg * s_reg;
            sps_reg   <= sin_pitch_reg * s_reg;
            fxc_reg   <= $signed({1'b0, focal_x_reg}) * c_reg;

            d_reg     <= 58'(cps_reg) + (58'(sin_pitch_reg) <<< 30);
            t_reg     <= (58'(cos_pitch_reg) <<< 30) - 58'(sps_reg);
            nu_reg    <= fxc_reg;

            hor5_reg  <= d_reg[57] || (d_reg == '0);
            negu5_reg <= nu_reg[61];
            negv5_reg <= t_reg[57];
            mu_reg    <= nu_reg[61] ? 61'(-nu_reg) : nu_reg[60:0];
            d5_reg    <= d_reg[56:0];
            pvl_reg   <= focal_y_reg * mt_next[28:0];
            pvh_reg   <= focal_y_reg * mt_next[56:29];

            hor6_reg  <= hor5_reg;
            negu6_reg <= negu5_reg;
            negv6_reg <= negv5_reg;
            numu_reg  <= NUM_W'({mu_reg, 11'd0}) + NUM_W'(d5_reg);
            numv_reg  <= NUM_W'({nv_next, 1'b0}) + NUM_W'({d5_reg, 4'd0});
            denu_reg  <= DEN_W'({d5_reg, 1'b0});
            denv_reg  <= DEN_W'({d5_reg, 5'd0});
        end
    end

    gip_tag_t         tag_in, tag_out;
    logic [QUO_W-1:0] quo_u, quo_v;
    logic             big_u, big_v;

    assign tag_in = '{valid: vld_reg[6], horizon: hor6_reg,
                      neg_u: negu6_reg, neg_v: negv6_reg};

    gip_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .tag_in  (tag_in),
        .num_u   (numu_reg),
        .den_u   (denu_reg),
        .num_v   (numv_reg),
        .den_v   (denv_reg),
        .tag_out (tag_out),
        .quo_u   (quo_u),
        .quo_v   (quo_v),
        .big_u   (big_u),
        .big_v   (big_v)
    );

    logic signed [20:0] su, sv, qu_s, qv_s;
    logic [OUT_W-1:0]   u_next, v_next;
    logic               sat_u, sat_v;
    gip_stat_t          stat_next;

    always_comb begin
        qu_s  = $signed({2'b00, quo_u});
        qv_s  = $signed({2'b00, quo_v});
        su    = $signed({4'd0, center_x_reg}) + (tag_out.neg_u ? -qu_s : qu_s);
        sv    = $signed({4'd0, center_y_reg}) + (tag_out.neg_v ? -qv_s : qv_s);
        sat_u = big_u || (su > OUT_MAX) || (su < OUT_MIN);
        sat_v = big_v || (sv > OUT_MAX) || (sv < OUT_MIN);
        if (big_u) begin
            u_next = tag_out.neg_u ? OUT_MIN[OUT_W-1:0] : OUT_MAX[OUT_W-1:0];
        end else if (su > OUT_MAX) begin
            u_next = OUT_MAX[OUT_W-1:0];
        end else if (su < OUT_MIN) begin
            u_next = OUT_MIN[OUT_W-1:0];
        end else begin
            u_next = su[OUT_W-1:0];
        end
        if (big_v) begin
            v_next = tag_out.neg_v ? OUT_MIN[OUT_W-1:0] : OUT_MAX[OUT_W-1:0];
        end else if (sv > OUT_MAX) begin
            v_next = OUT_MAX[OUT_W-1:0];
        end else if (sv < OUT_MIN) begin
            v_next = OUT_MIN[OUT_W-1:0];
        end else begin
            v_next = sv[OUT_W-1:0];
        end
        stat_next = (sat_u || sat_v) ? STAT_SAT : STAT_VALID;
        if (tag_out.horizon) begin
            u_next    = '0;
            v_next    = '0;
            stat_next = STAT_HORIZON;
        end
    end

    logic             out_vld_reg;
    logic [OUT_W-1:0] u_reg, v_reg;
    gip_stat_t        stat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= tag_out.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            stat_reg <= stat_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {4'd0, v_reg, u_reg};
    assign m_tuser  = stat_reg;

endmodule

// ===== rtl/gip_div.sv =====
// Pipelined restoring divider for the u and v quotients, one quotient bit per stage.
module gip_div
    import gip_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  gip_tag_t            tag_in,
    input  logic [NUM_W-1:0]    num_u,
    input  logic [DEN_W-1:0]    den_u,
    input  logic [NUM_W-1:0]    num_v,
    input  logic [DEN_W-1:0]    den_v,
    output gip_tag_t            tag_out,
    output logic [QUO_W-1:0]    quo_u,
    output logic [QUO_W-1:0]    quo_v,
    output logic                big_u,
    output logic                big_v
);

    gip_tag_t          tag_reg   [0:QUO_W];
    logic [REM_W-1:0]  rem_u_reg [0:QUO_W];
    logic [REM_W-1:0]  rem_v_reg [0:QUO_W];
    logic [DEN_W-1:0]  den_u_reg [0:QUO_W];
    logic [DEN_W-1:0]  den_v_reg [0:QUO_W];
    logic [QUO_W-1:0]  quo_u_reg [0:QUO_W];
    logic [QUO_W-1:0]  quo_v_reg [0:QUO_W];
    logic              big_u_reg [0:QUO_W];
    logic              big_v_reg [0:QUO_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg[0] <= '0;
        end else if (en) begin
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_u_reg[0] <= REM_W'(num_u);
            rem_v_reg[0] <= REM_W'(num_v);
            den_u_reg[0] <= den_u;
            den_v_reg[0] <= den_v;
            quo_u_reg[0] <= '0;
            quo_v_reg[0] <= '0;
            big_u_reg[0] <= REM_W'(num_u) >= (REM_W'(den_u) << QUO_W);
            big_v_reg[0] <= REM_W'(num_v) >= (REM_W'(den_v) << QUO_W);
        end
    end

    for (genvar j = 1; j <= QUO_W; j++) begin : g_stage
        localparam int B = QUO_W - j;
        logic [REM_W-1:0] dsh_u, dsh_v, rem_u_next, rem_v_next;
        logic [QUO_W-1:0] quo_u_next, quo_v_next;
        logic             ge_u, ge_v;

        always_comb begin
            dsh_u      = REM_W'(den_u_reg[j-1]) << B;
            dsh_v      = REM_W'(den_v_reg[j-1]) << B;
            ge_u       = rem_u_reg[j-1] >= dsh_u;
            ge_v       = rem_v_reg[j-1] >= dsh_v;
            rem_u_next = ge_u ? rem_u_reg[j-1] - dsh_u : rem_u_reg[j-1];
            rem_v_next = ge_v ? rem_v_reg[j-1] - dsh_v : rem_v_reg[j-1];
            quo_u_next = quo_u_reg[j-1] | (QUO_W'(ge_u) << B);
            quo_v_next = quo_v_reg[j-1] | (QUO_W'(ge_v) << B);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                tag_reg[j] <= '0;
            end else if (en) begin
                tag_reg[j] <= tag_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_u_reg[j] <= rem_u_next;
                rem_v_reg[j] <= rem_v_next;
                den_u_reg[j] <= den_u_reg[j-1];
                den_v_reg[j] <= den_v_reg[j-1];
                quo_u_reg[j] <= quo_u_next;
                quo_v_reg[j] <= quo_v_next;
                big_u_reg[j] <= big_u_reg[j-1];
                big_v_reg[j] <= big_v_reg[j-1];
            end
        end
    end

    assign tag_out = tag_reg[QUO_W];
    assign quo_u   = quo_u_reg[QUO_W];
    assign quo_v   = quo_v_reg[QUO_W];
    assign big_u   = big_u_reg[QUO_W];
    assign big_v   = big_v_reg[QUO_W];

endmodule

// ===== rtl/gip_checker.sv =====
// Port-level assertions for the projection top level and the bind that attaches them.
module gip_checker
    import gip_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_horizon_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_HORIZON) |-> (m_tdata[35:0] == '0))
        else $error("horizon result carries nonzero coordinates");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_VALID) || (m_tuser == STAT_HORIZON)
                     || (m_tuser == STAT_SAT))
        else $error("undefined status code");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output");

endmodule

bind ground_to_image_projection_top gip_checker u_gip_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the ground-to-image projection block.
`timescale 1ns / 100ps

module tb
    import gip_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic signed [OUT_W-1:0] u;
        logic signed [OUT_W-1:0] v;
        gip_stat_t               status;
    } pixel_t;

    class projection_board;
        bit [FOC_W-1:0] fx, fy;
        bit [CEN_W-1:0] cx, cy0;
        longint         cp, sp, cyaw, syaw;
        pixel_t         pixels_due[$];
        int             mismatches, checked, horizons, saturated;

        function new();
            fx = FOCAL_X_RST;
            fy = FOCAL_Y_RST;
            cx = CENTER_X_RST;
            cy0 = CENTER_Y_RST;
            cp = 16384;
            sp = 0;
            cyaw = 16384;
            syaw = 0;
        endfunction

        function void set_reg(gip_reg_t r, bit [31:0] val);
            case (r)
                REG_FOCAL_X:   fx = val[FOC_W-1:0];
                REG_FOCAL_Y:   fy = val[FOC_W-1:0];
                REG_CENTER_X:  cx = val[CEN_W-1:0];
                REG_CENTER_Y:  cy0 = val[CEN_W-1:0];
                REG_COS_PITCH: cp = longint'($signed(val[15:0]));
                REG_SIN_PITCH: sp = longint'($signed(val[15:0]));
                REG_COS_YAW:   cyaw = longint'($signed(val[15:0]));
                REG_SIN_YAW:   syaw = longint'($signed(val[15:0]));
                default: ;
            endcase
        endfunction

        function bit [127:0] round_quotient(bit [127:0] n, bit [127:0] den, ref bit big);
            bit [127:0] q;
            q = (2 * n + den) / (2 * den);
            if (q >= (128'd1 << 40)) begin
                big = 1;
                q = 128'd1 << 40;
            end
            return q;
        endfunction

        function longint clamp(longint val, ref bit sat);
            if (val > 131071) begin
                sat = 1;
                return 131071;
            end
            if (val < -131072) begin
                sat = 1;
                return -131072;
            end
            return val;
        endfunction

        function void note(logic [IN_W-1:0] gx, logic [IN_W-1:0] gy);
            longint x, y, s, c, d, t, nu, su, sv;
            bit [127:0] qu, qv, num, den;
            bit big, sat;
            pixel_t p;
            x = longint'($signed(gx));
            y = longint'($signed(gy));
            big = 0;
            sat = 0;
            s = syaw * x + cyaw * y;
            c = cyaw * x - syaw * y;
            d = cp * s + sp * 64'sd1073741824;
            t = cp * 64'sd1073741824 - sp * s;
            if (d <= 0) begin
                p.u = '0;
                p.v = '0;
                p.status = STAT_HORIZON;
                pixels_due = {pixels_due, p};
                return;
            end
            nu = longint'(fx) * c;
            num = (nu < 0) ? 128'(-nu) : 128'(nu);
            qu = round_quotient(num << 10, 128'(d), big);
            num = ((t < 0) ? 128'(-t) : 128'(t)) * 128'(fy);
            den = 128'(d) << 4;
            qv = round_quotient(num, den, big);
            su = longint'(cx) + ((nu < 0) ? -longint'(qu) : longint'(qu));
            sv = longint'(cy0) + ((t < 0) ? -longint'(qv) : longint'(qv));
            p.u = OUT_W'(clamp(su, sat));
            p.v = OUT_W'(clamp(sv, sat));
            p.status = (sat || big) ? STAT_SAT : STAT_VALID;
            pixels_due = {pixels_due, p};
        endfunction

        function void check(logic [OUT_W-1:0] u, logic [OUT_W-1:0] v, logic [1:0] st);
            pixel_t p;
            checked++;
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result u=%0d v=%0d status=%0d",
                             $signed(u), $signed(v), st);
                return;
            end
            p = pixels_due.pop_front();
            if (p.status == STAT_HORIZON) horizons++;
            if (p.status == STAT_SAT) saturated++;
            if (u !== p.u || v !== p.v || st !== p.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: result %0d expected u=%0d v=%0d status=%0d, ",
                              "got u=%0d v=%0d status=%0d"},
                             checked, p.u, p.v, p.status, $signed(u), $signed(v), st);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    projection_board board = new();
    bit calm = 0;
    int quiet_cycles = 0;

    ground_to_image_projection_top dut (.*);

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(negedge aclk)
        m_tready <= calm || ($urandom_range(99) >= 34);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check(m_tdata[17:0], m_tdata[35:18], m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** ground_to_image_projection_top: FAILED **");
            $finish;
        end
    end

    task automatic write_reg(gip_reg_t r, bit [31:0] val);
        @(negedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {r, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        board.set_reg(r, val);
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic load_camera(bit [19:0] fx, bit [19:0] fy, bit [16:0] cx, bit [16:0] cy0,
                               bit [15:0] cp, bit [15:0] sp, bit [15:0] cyaw, bit [15:0] syaw);
        while (board.pixels_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        write_reg(REG_FOCAL_X, 32'(fx));
        write_reg(REG_FOCAL_Y, 32'(fy));
        write_reg(REG_CENTER_X, 32'(cx));
        write_reg(REG_CENTER_Y, 32'(cy0));
        write_reg(REG_COS_PITCH, 32'(cp));
        write_reg(REG_SIN_PITCH, 32'(sp));
        write_reg(REG_COS_YAW, 32'(cyaw));
        write_reg(REG_SIN_YAW, 32'(syaw));
    endtask

    task automatic send_point(logic [23:0] gx, logic [23:0] gy);
        if (!calm)
            while ($urandom_range(99) < 34) begin
                s_tvalid <= 0;
                @(negedge aclk);
            end
        s_tvalid <= 1;
        s_tdata <= {gy, gx};
        do @(posedge aclk); while (!s_tready);
        board.note(gx, gy);
        @(negedge aclk);
    endtask

    task automatic send_random(int count);
        longint y, x;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 70) begin
                y = $urandom_range(3276800, 16384);
                x = longint'($urandom_range(32'(4 * y))) - 2 * y;
                if (x > 8388607) x = 8388607;
                if (x < -8388608) x = -8388608;
                send_point(x[23:0], y[23:0]);
            end else begin
                send_point(24'($urandom), 24'($urandom));
            end
        end
        s_tvalid <= 0;
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        @(negedge aclk);

        send_point(24'd0, 24'd0);
        send_point(24'd0, 24'd65536);
        send_point(24'd65536, 24'd65536);
        send_point(-24'sd65536, 24'd131072);
        send_point(24'h7fffff, 24'h7fffff);
        send_point(24'h800000, 24'h800000);
        send_point(24'h7fffff, 24'h800000);
        send_point(24'h800000, 24'h7fffff);
        send_point(24'd0, -24'sd65536);
        send_point(24'h7fffff, 24'd1);
        send_point(24'h800000, 24'd1);
        send_point(24'd1, 24'd1);
        send_point(-24'sd1, 24'd65536);
        send_point(24'd0, 24'h7fffff);
        send_point(24'd1000, 24'h7fffff);
        send_point(24'hffffff, 24'hffffff);
        s_tvalid <= 0;
        send_random(70);

        load_camera(20'd200000, 20'd200000, 17'd10240, 17'd5760,
                    16'd15137, 16'd6270, 16'd15137, -16'sd6270);
        send_random(80);

        calm = 1;
        load_camera(20'hfffff, 20'd0, 17'd0, 17'h1ffff,
                    -16'sd16384, 16'd16384, -16'sd16384, 16'd16384);
        send_random(80);
        calm = 0;

        load_camera(20'd0, 20'hfffff, 17'h1ffff, 17'd0,
                    16'd0, 16'd16384, 16'd16384, -16'sd16384);
        send_random(80);

        load_camera(20'($urandom), 20'($urandom), 17'($urandom), 17'($urandom),
                    16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        send_random(50);
        load_camera(20'd433948, 20'd435026, 17'd26424, 17'd39950,
                    16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_random(40);

        while (board.pixels_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Checked %0d projected points over six camera settings and register extremes.",
                 board.checked);
        $display("Of these, %0d fell at or behind the horizon and %0d were clamped; %0d mismatches.",
                 board.horizons, board.saturated, board.mismatches);
        if (board.mismatches == 0)
            $display("** ground_to_image_projection_top: PASSED **");
        else
            $display("** ground_to_image_projection_top: FAILED **");
        $finish;
    end

endmodule
